// ----- design/fcrc_pkg.sv -----
// Package: shared constants, types and the CRC-16 byte update for the frame checker.
`timescale 1ns / 1ps

package fcrc_pkg;

    // Field and register widths
    localparam int unsigned POS_W  = 12;
    localparam int unsigned CRC_W  = 16;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_W  = 12;
    localparam int unsigned IDX_W  = 1;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_FRAME_LENGTH    = 1'b0;
    localparam logic [IDX_W-1:0] CFG_CHECKSUM_OFFSET = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_LENGTH_RST    = 12'd8;
    localparam logic [CFG_W-1:0] CHECKSUM_OFFSET_RST = 12'd6;

    // Non-reflected CRC-16 generator
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hAC9A;

    // One result beat
    typedef struct packed {
        logic [CNT_W-1:0] frame_number;
        logic             crc_match;
        logic [CRC_W-1:0] computed_crc;
        logic [CRC_W-1:0] received_crc;
    } res_t;

    // MSB-first CRC update over one byte, eight shift steps
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- design/fcrc_channels.sv -----
// Stream interfaces: received byte channel and frame result channel.
`timescale 1ns / 1ps

interface fcrc_byte_if
    import fcrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface fcrc_res_if
    import fcrc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] frame_number;
    logic             crc_match;
    logic [CRC_W-1:0] computed_crc;
    logic [CRC_W-1:0] received_crc;

    modport source (output valid, output frame_number, output crc_match,
                    output computed_crc, output received_crc, input ready);
    modport sink   (input valid, input frame_number, input crc_match,
                    input computed_crc, input received_crc, output ready);
endinterface

// ----- design/fixed_frame_crc16_checker_unit.sv -----
// Top level: fixed-length frame CRC-16 checker.
//
// Usage:
//   rx   - byte channel (valid/ready), one received byte per beat.
//   res  - result channel, one beat per completed frame: frame number,
//          match flag, computed CRC and received CRC.
//   cfg_* - plain write port for frame_length and checksum_offset; write
//          only while no byte or result is in flight.
// Path: a byte taken from rx lands in the input register and is then folded
//   into the frame state registers; a frame's last byte loads the result
//   register, which drives res.
// Throughput: one byte per cycle, save where a frame-ending byte is held
//   (see Stall). The per-byte CRC update is a single eight-step table-free
//   shift network between the input register and the frame state registers.
// Reset: frame state and frame count clear, registers return to a frame
//   length of 8 and a checksum offset of 6; both channels go idle.
// Stall: while a result waits on res, bytes that do not end a frame keep
//   flowing; a frame-ending byte holds in the input register until the
//   result register frees, and rx.ready drops behind it.
`timescale 1ns / 1ps

module fixed_frame_crc16_checker_unit
    import fcrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    fcrc_byte_if.sink        rx,
    fcrc_res_if.source       res
);

    // Configuration registers
    logic [CFG_W-1:0] frame_length_reg;
    logic [CFG_W-1:0] checksum_offset_reg;

    // Input register
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    // Frame state
    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [CRC_W-1:0] running_crc_reg, running_crc_next;
    logic [CRC_W-1:0] captured_crc_reg, captured_crc_next;
    logic [CNT_W-1:0] frame_count_reg;

    // Result register
    logic out_valid_reg;
    res_t out_reg, out_next;

    logic [POS_W:0] pos_x, off_x, len_x;
    logic           pos_lt, pos_eq, pos_eq1, last, fits;
    logic           out_free, s1_go, out_load;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg    <= FRAME_LENGTH_RST;
            checksum_offset_reg <= CHECKSUM_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_LENGTH:    frame_length_reg    <= cfg_wdata;
                CFG_CHECKSUM_OFFSET: checksum_offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Position compares, one bit wider to hold offset + 2
    assign pos_x   = {1'b0, byte_position_reg};
    assign off_x   = {1'b0, checksum_offset_reg};
    assign len_x   = {1'b0, frame_length_reg};
    assign pos_lt  = pos_x < off_x;
    assign pos_eq  = pos_x == off_x;
    assign pos_eq1 = pos_x == off_x + 13'd1;
    assign last    = pos_x + 13'd1 >= len_x;
    assign fits    = off_x + 13'd2 <= len_x;

    // Flow control
    assign out_free = !out_valid_reg || res.ready;
    assign s1_go    = s1_valid_reg && (!last || out_free);
    assign out_load = s1_go && last;
    assign rx.ready = !s1_valid_reg || s1_go;

    // Per-byte frame update
    always_comb
    begin
        running_crc_next  = running_crc_reg;
        captured_crc_next = captured_crc_reg;
        if (pos_lt)
            running_crc_next = crc_byte(running_crc_reg, s1_byte_reg);
        else if (pos_eq)
            captured_crc_next = {s1_byte_reg, captured_crc_reg[7:0]};
        else if (pos_eq1)
            captured_crc_next = {captured_crc_reg[15:8], s1_byte_reg};
        byte_position_next = byte_position_reg + 12'd1;

        out_next.frame_number = frame_count_reg;
        out_next.computed_crc = running_crc_next;
        out_next.received_crc = captured_crc_next;
        out_next.crc_match    = fits && (running_crc_next == captured_crc_next);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.ready)
            s1_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            s1_byte_reg <= rx.data_byte;
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            running_crc_reg   <= '0;
            captured_crc_reg  <= '0;
            frame_count_reg   <= '0;
        end
        else if (s1_go)
        begin
            if (last)
            begin
                byte_position_reg <= '0;
                running_crc_reg   <= '0;
                captured_crc_reg  <= '0;
                frame_count_reg   <= frame_count_reg + 16'd1;
            end
            else
            begin
                byte_position_reg <= byte_position_next;
                running_crc_reg   <= running_crc_next;
                captured_crc_reg  <= captured_crc_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.frame_number = out_reg.frame_number;
    assign res.crc_match    = out_reg.crc_match;
    assign res.computed_crc = out_reg.computed_crc;
    assign res.received_crc = out_reg.received_crc;

endmodule

// ----- design/fcrc_checker.sv -----
// Port-level assertions for the frame checker, bound to the top level.
`timescale 1ns / 1ps

module fcrc_checker
    import fcrc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic [CNT_W-1:0] frame_number,
    input logic             crc_match,
    input logic [CRC_W-1:0] computed_crc,
    input logic [CRC_W-1:0] received_crc
);

    // Track the last delivered frame number
    logic             seen_reg;
    logic [CNT_W-1:0] last_fn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            last_fn_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            seen_reg    <= 1'b1;
            last_fn_reg <= frame_number;
        end
    end

    // Stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(frame_number)
            && $stable(crc_match) && $stable(computed_crc) && $stable(received_crc))
        else $error("result beat changed while stalled");

    // Match flag never set on differing CRCs
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && crc_match |-> computed_crc == received_crc)
        else $error("match flag set on differing CRCs");

    // First frame after reset is frame zero
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !seen_reg |-> frame_number == '0)
        else $error("first frame number is not zero");

    // Frame numbers step by one, none lost or repeated
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_reg |-> frame_number == last_fn_reg + 16'd1)
        else $error("frame number did not advance by one");

endmodule

bind fixed_frame_crc16_checker_unit fcrc_checker u_fcrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .frame_number (res.frame_number),
    .crc_match    (res.crc_match),
    .computed_crc (res.computed_crc),
    .received_crc (res.received_crc)
);

// ----- sim/tb_fixed_frame_crc16_checker_unit.sv -----
// Testbench: fixed-length frame CRC-16 checker, directed table then random frames vs a predictor.
`timescale 1ns / 1ps

module tb_fixed_frame_crc16_checker_unit;
    import fcrc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

    // One line of the directed plan: a register setting or a byte
    typedef struct {
        row_kind_t        kind;
        logic [CFG_W-1:0] len;
        logic [CFG_W-1:0] off;
        logic [7:0]       b;
        bit               typed;
        res_t             want;
    } row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    fcrc_byte_if rx_ch ();
    fcrc_res_if  res_ch ();

    fixed_frame_crc16_checker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    // Predicted frame state and register copies
    int unsigned      cur_frame_len = 32'(FRAME_LENGTH_RST);
    int unsigned      cur_crc_off   = 32'(CHECKSUM_OFFSET_RST);
    int unsigned      byte_pos      = 0;
    logic [CRC_W-1:0] run_crc       = '0;
    logic [CRC_W-1:0] cap_crc       = '0;
    logic [CNT_W-1:0] frame_cnt     = '0;

    res_t frames_due[$];
    row_t plan[$];
    int   errors    = 0;
    bit   calm      = 1'b0;
    bit   timed_out = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bitwise MSB-first CRC-16, data bit fed against the top of the register
    function automatic logic [CRC_W-1:0] crc16_shift(input logic [CRC_W-1:0] crc,
                                                     input logic [7:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ b[i];
            c = {c[CRC_W-2:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Append one expected frame result
    function automatic void queue_frame(input res_t r);
        frames_due.insert(frames_due.size(), r);
    endfunction

    // Append one line to the directed plan
    function automatic void add_row(input row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // Fold one accepted byte into the predicted frame; done marks a frame end
    task automatic fold_byte(input logic [7:0] b, output bit done, output res_t r);
        int unsigned p;
        p = byte_pos;
        r = '0;
        if (p < cur_crc_off)
            run_crc = crc16_shift(run_crc, b);
        else if (p == cur_crc_off)
            cap_crc[15:8] = b;
        else if (p == cur_crc_off + 1)
            cap_crc[7:0] = b;
        done = (p + 1 >= cur_frame_len);
        if (!done)
            byte_pos = (p + 1) & 32'hFFF;
        else
        begin
            r.frame_number = frame_cnt;
            r.crc_match    = (cur_crc_off + 2 <= cur_frame_len) && (run_crc == cap_crc);
            r.computed_crc = run_crc;
            r.received_crc = cap_crc;
            frame_cnt++;
            byte_pos = 0;
            run_crc  = '0;
            cap_crc  = '0;
        end
    endtask

    // Drive one byte beat; a frame end queues its expected result
    task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
        bit   done;
        res_t r;
        if (!calm)
            while ($urandom_range(0, 99) < 21)
            begin
                rx_ch.valid <= 1'b0;
                @(posedge clk);
            end
        rx_ch.valid     <= 1'b1;
        rx_ch.data_byte <= b;
        @(posedge clk);
        while (!(rx_ch.valid && rx_ch.ready))
            @(posedge clk);
        fold_byte(b, done, r);
        if (done)
            queue_frame(typed ? want : r);
    endtask

    // Wait for the block to go quiet, then write both registers
    task automatic set_frame(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] off);
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_LENGTH;
        cfg_wdata <= len;
        @(posedge clk);
        cur_frame_len = 32'(len);
        cfg_index <= CFG_CHECKSUM_OFFSET;
        cfg_wdata <= off;
        @(posedge clk);
        cur_crc_off = 32'(off);
        cfg_we <= 1'b0;
    endtask

    // One frame of random bytes; most carry a valid CRC field, some get a bit flipped
    task automatic send_frame(input int unsigned flen, input int unsigned off);
        logic [7:0]       frame_buf[$];
        logic [CRC_W-1:0] acc;
        int unsigned      hit;
        for (int unsigned i = 0; i < flen; i++)
            frame_buf = {frame_buf, 8'($urandom)};
        if (off + 2 <= flen && $urandom_range(0, 99) < 80)
        begin
            acc = '0;
            for (int unsigned i = 0; i < off; i++)
                acc = crc16_shift(acc, frame_buf[i]);
            frame_buf[off]     = acc[15:8];
            frame_buf[off + 1] = acc[7:0];
            if ($urandom_range(0, 99) < 20)
            begin
                hit = $urandom_range(0, flen - 1);
                frame_buf[hit] = frame_buf[hit] ^ 8'(1 << $urandom_range(0, 7));
            end
        end
        foreach (frame_buf[i])
            send_byte(frame_buf[i], 1'b0, '0);
    endtask

    function automatic row_t cfg_row(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] off);
        row_t r;
        r = '{kind: ROW_CFG, len: len, off: off, b: '0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic row_t byte_row(input logic [7:0] b);
        row_t r;
        r = '{kind: ROW_BYTE, len: '0, off: '0, b: b, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic row_t checked_row(input logic [7:0] b, input logic [15:0] fn,
                                         input logic m, input logic [15:0] comp,
                                         input logic [15:0] recv);
        row_t r;
        r = byte_row(b);
        r.typed = 1'b1;
        r.want  = '{frame_number: fn, crc_match: m, computed_crc: comp, received_crc: recv};
        return r;
    endfunction

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        errors++;
        $display("%0t: %s expected %h got %h", $time, name, want, got);
    endtask

    // Result receiver: random stalls outside calm stretches
    always @(posedge clk)
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 21);

    // Compare each result beat with the oldest expected frame
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (frames_due.size() == 0)
            begin
                errors++;
                $display("%0t: result frame %0d with none expected", $time,
                         res_ch.frame_number);
            end
            else
            begin
                want = frames_due.pop_front();
                if (res_ch.frame_number !== want.frame_number)
                    report_field("frame_number", want.frame_number, res_ch.frame_number);
                if (res_ch.crc_match !== want.crc_match)
                    report_field("crc_match", 16'(want.crc_match), 16'(res_ch.crc_match));
                if (res_ch.computed_crc !== want.computed_crc)
                    report_field("computed_crc", want.computed_crc, res_ch.computed_crc);
                if (res_ch.received_crc !== want.received_crc)
                    report_field("received_crc", want.received_crc, res_ch.received_crc);
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_FRAME_LENGTH;
        cfg_wdata       <= '0;
        rx_ch.valid     <= 1'b0;
        rx_ch.data_byte <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin : stimulus
                int unsigned len;
                int unsigned off;
                int unsigned sel;
                int unsigned rand_bytes;
                int          phase_no;

                // Reset settings: eight zero bytes check clean
                repeat (7) add_row(byte_row(8'h00));
                add_row(checked_row(8'h00, 16'd0, 1'b1, 16'h0000, 16'h0000));
                // Shortest legal frame, CRC field at the start
                add_row(cfg_row(12'd2, 12'd0));
                add_row(byte_row(8'hFF));
                add_row(checked_row(8'hFF, 16'd1, 1'b0, 16'h0000, 16'hFFFF));
                add_row(byte_row(8'h00));
                add_row(checked_row(8'h00, 16'd2, 1'b1, 16'h0000, 16'h0000));
                // Frame length 0 and 1: each byte is its own frame, field never fits
                add_row(cfg_row(12'd0, 12'd0));
                add_row(checked_row(8'h5A, 16'd3, 1'b0, 16'h0000, 16'h5A00));
                add_row(cfg_row(12'd1, 12'd0));
                add_row(checked_row(8'h80, 16'd4, 1'b0, 16'h0000, 16'h8000));
                // Offset at the top of its range: CRC over the whole frame
                add_row(cfg_row(12'd3, 12'd4095));
                add_row(byte_row(8'h01));
                add_row(byte_row(8'h02));
                add_row(byte_row(8'h03));
                // 00 01 hashes to the polynomial itself
                add_row(cfg_row(12'd4, 12'd2));
                add_row(byte_row(8'h00));
                add_row(byte_row(8'h01));
                add_row(byte_row(8'hAC));
                add_row(checked_row(8'h9A, 16'd6, 1'b1, 16'hAC9A, 16'hAC9A));
                // Frame length lowered mid-frame: next byte closes the frame
                add_row(cfg_row(12'd8, 12'd6));
                add_row(byte_row(8'h11));
                add_row(byte_row(8'h22));
                add_row(byte_row(8'h33));
                add_row(cfg_row(12'd2, 12'd6));
                add_row(byte_row(8'h44));

                foreach (plan[k])
                begin
                    if (plan[k].kind == ROW_CFG)
                        set_frame(plan[k].len, plan[k].off);
                    else
                        send_byte(plan[k].b, plan[k].typed, plan[k].want);
                end

                // Random phases: mostly short frames, some odd offsets
                rand_bytes  = 0;
                phase_no    = 0;
                while (rand_bytes < 570)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 6)
                        len = $urandom_range(0, 1);
                    else if (sel < 16)
                        len = 2;
                    else if (sel < 26)
                        len = 3;
                    else if (sel < 90)
                        len = $urandom_range(4, 24);
                    else
                        len = $urandom_range(25, 300);

                    sel = $urandom_range(0, 99);
                    if (len >= 2 && sel < 70)
                        off = $urandom_range(0, len - 2);
                    else if (sel < 82)
                        off = (len == 0) ? 0 : len - 1 + $urandom_range(0, 1);
                    else if (sel < 92)
                        off = $urandom_range(0, 4095);
                    else
                        off = $urandom_range(4093, 4095);

                    calm = (phase_no >= 3 && phase_no < 7);
                    set_frame(12'(len), 12'(off));
                    repeat ($urandom_range(1, 4))
                    begin
                        send_frame((len < 2) ? 1 : len, off);
                        rand_bytes += (len < 2) ? 1 : len;
                    end
                    // Occasional stray bytes leave the next setting mid-frame
                    if ($urandom_range(0, 99) < 12)
                        repeat ($urandom_range(1, 5))
                        begin
                            send_byte(8'($urandom), 1'b0, '0);
                            rand_bytes++;
                        end
                    phase_no++;
                end
                calm = 1'b0;

                rx_ch.valid <= 1'b0;
                while (frames_due.size() != 0)
                    @(posedge clk);
                repeat (8) @(posedge clk);
            end
            begin : watchdog
                int quiet;
                quiet = 0;
                while (quiet < STALL_LIMIT)
                begin
                    @(posedge clk);
                    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                        quiet = 0;
                    else
                        quiet++;
                end
                timed_out = 1'b1;
                $display("%0t: no beat for %0d cycles, run stopped", $time, STALL_LIMIT);
            end
        join_any

        if (frames_due.size() != 0)
        begin
            errors += frames_due.size();
            $display("%0t: %0d frame results never arrived", $time, frames_due.size());
        end
        if (!timed_out && errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
